/* design/ccde_pkg.sv */
// shared types, codes and constants of the character canvas draw engine
package ccde_pkg;

	localparam int DEF_COLS = 80;
	localparam int DEF_ROWS = 24;

	localparam int CHAR_W  = 8;
	localparam int POS_W   = 9;
	localparam int OP_W    = 4;
	localparam int LEN_W   = 8;
	// coordinates reach from -511 to 510 while walking a primitive
	localparam int COORD_W = 11;
	// longest run is a centered triangle row of 2*254+1 cells
	localparam int CNT_W   = 9;

	localparam logic [CHAR_W-1:0] RESET_BLANK = 8'd32;

	localparam logic [OP_W-1:0] OP_CLEAR  = 4'd0;
	localparam logic [OP_W-1:0] OP_POINT  = 4'd1;
	localparam logic [OP_W-1:0] OP_HLINE  = 4'd2;
	localparam logic [OP_W-1:0] OP_VLINE  = 4'd3;
	localparam logic [OP_W-1:0] OP_RECT   = 4'd4;
	localparam logic [OP_W-1:0] OP_FILL   = 4'd5;
	localparam logic [OP_W-1:0] OP_TRI_R  = 4'd6;
	localparam logic [OP_W-1:0] OP_TRI_C  = 4'd7;
	localparam logic [OP_W-1:0] OP_DIAG_R = 4'd8;
	localparam logic [OP_W-1:0] OP_DIAG_L = 4'd9;
	localparam logic [OP_W-1:0] OP_READ   = 4'd10;

	typedef logic [3:0] run_t;

	localparam run_t RUN_NONE   = 4'd0;
	localparam run_t RUN_POINT  = 4'd1;
	localparam run_t RUN_HLINE  = 4'd2;
	localparam run_t RUN_VLINE  = 4'd3;
	localparam run_t RUN_HTOP   = 4'd4;
	localparam run_t RUN_HBOT   = 4'd5;
	localparam run_t RUN_VLEFT  = 4'd6;
	localparam run_t RUN_VRIGHT = 4'd7;
	localparam run_t RUN_FILL   = 4'd8;
	localparam run_t RUN_TRI_R  = 4'd9;
	localparam run_t RUN_TRI_C  = 4'd10;
	localparam run_t RUN_DIAG_R = 4'd11;
	localparam run_t RUN_DIAG_L = 4'd12;

	typedef struct packed {
		logic capture;
		logic setup;
		logic step;
		logic outer_inc;
		logic outer_clr;
		logic sweep;
		logic sweep_init;
		logic rd_en;
		logic out_load;
		logic out_read;
		run_t run_sel;
	} cmd_t;

	typedef struct packed {
		logic run_empty;
		logic run_last;
		logic outer_end;
		logic sweep_last;
	} sts_t;

endpackage

/* design/ccde_ram.sv */
// generic single write port ram with registered read
module ccde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1920
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/ccde_ctrl.sv */
// command sequencer: walks each primitive as a list of cell runs
module ccde_ctrl
	import ccde_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [OP_W-1:0] op,
	input  logic            fill_enable,
	output logic            out_valid,
	input  logic            out_stall,
	output cmd_t            cmd,
	input  sts_t            sts
);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SETUP = 3'd2;
	localparam logic [2:0] S_RUN   = 3'd3;
	localparam logic [2:0] S_SWEEP = 3'd4;
	localparam logic [2:0] S_READ  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]      state_q, state_d;
	run_t            run_q, run_d;
	logic [OP_W-1:0] op_q;
	logic            out_valid_q;
	logic            finish;
	logic            move_on;

	function automatic run_t first_run(input logic [OP_W-1:0] o, input logic f);
		run_t r;
		case (o)
			OP_POINT:  r = RUN_POINT;
			OP_HLINE:  r = RUN_HLINE;
			OP_VLINE:  r = RUN_VLINE;
			OP_RECT:   r = f ? RUN_FILL : RUN_HTOP;
			OP_FILL:   r = RUN_FILL;
			OP_TRI_R:  r = RUN_TRI_R;
			OP_TRI_C:  r = RUN_TRI_C;
			OP_DIAG_R: r = RUN_DIAG_R;
			OP_DIAG_L: r = RUN_DIAG_L;
			default:   r = RUN_NONE;
		endcase
		return r;
	endfunction

	// only the rectangle chains several runs
	function automatic run_t next_run(input logic [OP_W-1:0] o, input run_t cur);
		run_t r;
		case (cur)
			RUN_FILL:  r = (o == OP_RECT) ? RUN_HTOP : RUN_NONE;
			RUN_HTOP:  r = RUN_HBOT;
			RUN_HBOT:  r = RUN_VLEFT;
			RUN_VLEFT: r = RUN_VRIGHT;
			default:   r = RUN_NONE;
		endcase
		return r;
	endfunction

	function automatic logic is_outer(input run_t cur);
		return cur == RUN_FILL || cur == RUN_TRI_R || cur == RUN_TRI_C;
	endfunction

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		run_d       = run_q;
		cmd         = '0;
		cmd.run_sel = run_q;
		finish      = 1'b0;
		move_on     = 1'b0;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep      = 1'b1;
				cmd.sweep_init = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (op)
						OP_CLEAR: state_d = S_SWEEP;
						OP_READ: begin
							run_d   = RUN_POINT;
							state_d = S_SETUP;
						end
						default: begin
							run_d   = first_run(op, fill_enable);
							state_d = (run_d == RUN_NONE) ? S_DONE : S_SETUP;
						end
					endcase
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				if (op_q == OP_READ) begin
					state_d = S_READ;
				end else if (is_outer(run_q) && sts.outer_end) begin
					move_on = 1'b1;
				end else if (sts.run_empty) begin
					finish = 1'b1;
				end else begin
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				cmd.step = 1'b1;
				if (sts.run_last) begin
					finish = 1'b1;
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				cmd.out_read = op_q == OP_READ;
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// end of one run: next row of an outer loop, or next run of the command
		if (finish) begin
			if (is_outer(run_q)) begin
				cmd.outer_inc = 1'b1;
				state_d       = S_SETUP;
			end else begin
				move_on = 1'b1;
			end
		end
		if (move_on) begin
			cmd.outer_clr = 1'b1;
			run_d         = next_run(op_q, run_q);
			state_d       = (run_d == RUN_NONE) ? S_DONE : S_SETUP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			run_q       <= RUN_NONE;
			op_q        <= OP_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			run_q   <= run_d;
			if (cmd.capture) begin
				op_q <= op;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/ccde_dp.sv */
// datapath: command fields, run walker, frame store and result register
module ccde_dp
	import ccde_pkg::*;
#(
	parameter int CANVAS_COLS = DEF_COLS,
	parameter int CANVAS_ROWS = DEF_ROWS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic signed [POS_W-1:0]  row_pos,
	input  logic signed [POS_W-1:0]  col_pos,
	input  logic [LEN_W-1:0]         span_length,
	input  logic [LEN_W-1:0]         box_height,
	input  logic [CHAR_W-1:0]        draw_char,
	input  logic [CHAR_W-1:0]        fill_char,
	input  logic                     cfg_valid,
	input  logic [CHAR_W-1:0]        blank_char,
	output logic [CHAR_W-1:0]        read_char,
	output logic                     off_canvas
);

	localparam int CELLS  = CANVAS_ROWS * CANVAS_COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(CANVAS_ROWS);
	localparam int COL_W  = $clog2(CANVAS_COLS);

	typedef logic signed [COORD_W-1:0] coord_t;

	logic signed [POS_W-1:0] r_q, c_q;
	logic [LEN_W-1:0]        len_q, h_q;
	logic [CHAR_W-1:0]       dch_q, fch_q;
	logic [CHAR_W-1:0]       blank_q;

	coord_t                  row_q, col_q;
	logic                    dr_q;
	logic signed [1:0]       dc_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [LEN_W-1:0]        idx_q;
	logic [ADDR_W-1:0]       sweep_q;
	logic [CHAR_W-1:0]       rchar_q;
	logic                    off_q;

	coord_t                  st_row, st_col, r_x, c_x, h_x, len_x, i_x;
	logic                    st_dr;
	logic signed [1:0]       st_dc;
	logic [CNT_W-1:0]        st_n;
	logic [LEN_W-1:0]        outer_cnt;
	logic                    on_canvas;
	logic [ADDR_W-1:0]       cell_addr;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [CHAR_W-1:0]       ram_wdata;
	logic [CHAR_W-1:0]       ram_rdata;

	assign r_x   = coord_t'(r_q);
	assign c_x   = coord_t'(c_q);
	assign h_x   = $signed({{(COORD_W-LEN_W){1'b0}}, h_q});
	assign len_x = $signed({{(COORD_W-LEN_W){1'b0}}, len_q});
	assign i_x   = $signed({{(COORD_W-LEN_W){1'b0}}, idx_q});

	// start cell, direction and length of the selected run
	always_comb begin
		st_row    = r_x;
		st_col    = c_x;
		st_dr     = 1'b0;
		st_dc     = 2'sd1;
		st_n      = CNT_W'(len_q);
		outer_cnt = '0;
		unique case (cmd.run_sel) inside
			RUN_POINT: st_n = CNT_W'(1);
			RUN_HLINE, RUN_HTOP: ;
			RUN_VLINE: begin
				st_dr = 1'b1;
				st_dc = 2'sd0;
			end
			RUN_HBOT: st_row = r_x + h_x - coord_t'(1);
			RUN_VLEFT: begin
				st_dr = 1'b1;
				st_dc = 2'sd0;
				st_n  = CNT_W'(h_q);
			end
			RUN_VRIGHT: begin
				st_col = c_x + len_x - coord_t'(1);
				st_dr  = 1'b1;
				st_dc  = 2'sd0;
				st_n   = CNT_W'(h_q);
			end
			RUN_FILL: begin
				st_row    = r_x + i_x + coord_t'(1);
				st_col    = c_x + coord_t'(1);
				st_n      = (len_q >= LEN_W'(2)) ? CNT_W'(len_q - LEN_W'(2)) : '0;
				outer_cnt = (h_q >= LEN_W'(2)) ? h_q - LEN_W'(2) : '0;
			end
			RUN_TRI_R: begin
				st_row    = r_x + i_x;
				st_n      = CNT_W'(idx_q) + CNT_W'(1);
				outer_cnt = h_q;
			end
			RUN_TRI_C: begin
				st_row    = r_x + i_x;
				st_col    = c_x - i_x;
				st_n      = {idx_q, 1'b1};
				outer_cnt = h_q;
			end
			RUN_DIAG_R: st_dr = 1'b1;
			RUN_DIAG_L: begin
				st_dr = 1'b1;
				st_dc = -2'sd1;
			end
			default: st_n = '0;
		endcase
	end

	assign on_canvas = row_q >= coord_t'(0) && row_q < coord_t'(CANVAS_ROWS)
		&& col_q >= coord_t'(0) && col_q < coord_t'(CANVAS_COLS);

	assign cell_addr = ADDR_W'(row_q[ROW_W-1:0]) * ADDR_W'(CANVAS_COLS)
		+ ADDR_W'(col_q[COL_W-1:0]);

	assign sts.run_empty  = st_n == '0;
	assign sts.run_last   = cnt_q == CNT_W'(1);
	assign sts.outer_end  = idx_q >= outer_cnt;
	assign sts.sweep_last = sweep_q == ADDR_W'(CELLS - 1);

	assign ram_we    = cmd.sweep || (cmd.step && on_canvas);
	assign ram_waddr = cmd.sweep ? sweep_q : cell_addr;
	always_comb begin
		if (cmd.sweep) begin
			ram_wdata = cmd.sweep_init ? RESET_BLANK : blank_q;
		end else begin
			ram_wdata = (cmd.run_sel == RUN_FILL) ? fch_q : dch_q;
		end
	end

	ccde_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_en && on_canvas),
		.raddr(cell_addr),
		.rdata(ram_rdata)
	);

	// command fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			r_q   <= row_pos;
			c_q   <= col_pos;
			len_q <= span_length;
			h_q   <= box_height;
			dch_q <= draw_char;
			fch_q <= fill_char;
		end
	end

	// run walker
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			row_q <= st_row;
			col_q <= st_col;
			dr_q  <= st_dr;
			dc_q  <= st_dc;
			cnt_q <= st_n;
		end else if (cmd.step) begin
			row_q <= row_q + coord_t'({1'b0, dr_q});
			col_q <= col_q + coord_t'(dc_q);
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			sweep_q <= '0;
			blank_q <= RESET_BLANK;
			rchar_q <= '0;
			off_q   <= 1'b0;
		end else begin
			if (cmd.outer_clr) begin
				idx_q <= '0;
			end else if (cmd.outer_inc) begin
				idx_q <= idx_q + LEN_W'(1);
			end
			if (cmd.sweep) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + ADDR_W'(1);
			end
			if (cfg_valid) begin
				blank_q <= blank_char;
			end
			if (cmd.out_load) begin
				rchar_q <= (cmd.out_read && on_canvas) ? ram_rdata : '0;
				off_q   <= cmd.out_read && !on_canvas;
			end
		end
	end

	assign read_char  = rchar_q;
	assign off_canvas = off_q;

endmodule

/* design/char_canvas_draw_engine_top.sv */
// top level of the character canvas draw engine
//
//   channel   direction  handshake             word
//   in        input      in_valid / in_stall   op, row_pos, col_pos, span_length,
//                                              box_height, draw_char, fill_char,
//                                              fill_enable
//   out       output     out_valid / out_stall read_char, off_canvas
//   cfg       input      cfg_valid / cfg_ready blank_char
//
// one command at a time; every cell of a primitive is stepped through, on or off the
// canvas, but only cells on the canvas are written; each run or row starts in a setup
// state, and each command ends through the done state
// after reset a clearing pass over all rows*cols cells (1920 by default) holds in_stall
// the result sits in an output register, so a stalled result only blocks the
// finish of the following command
module char_canvas_draw_engine_top
	import ccde_pkg::*;
#(
	parameter int CANVAS_COLS = DEF_COLS,
	parameter int CANVAS_ROWS = DEF_ROWS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [OP_W-1:0]         op,
	input  logic signed [POS_W-1:0] row_pos,
	input  logic signed [POS_W-1:0] col_pos,
	input  logic [LEN_W-1:0]        span_length,
	input  logic [LEN_W-1:0]        box_height,
	input  logic [CHAR_W-1:0]       draw_char,
	input  logic [CHAR_W-1:0]       fill_char,
	input  logic                    fill_enable,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CHAR_W-1:0]       read_char,
	output logic                    off_canvas,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CHAR_W-1:0]       blank_char
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ccde_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.fill_enable(fill_enable),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	ccde_dp #(
		.CANVAS_COLS(CANVAS_COLS),
		.CANVAS_ROWS(CANVAS_ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.row_pos    (row_pos),
		.col_pos    (col_pos),
		.span_length(span_length),
		.box_height (box_height),
		.draw_char  (draw_char),
		.fill_char  (fill_char),
		.cfg_valid  (cfg_valid),
		.blank_char (blank_char),
		.read_char  (read_char),
		.off_canvas (off_canvas)
	);

endmodule

/* design/ccde_chk.sv */
// port level checker for the draw engine and its bind
module ccde_chk
	import ccde_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [CHAR_W-1:0] read_char,
	input logic              off_canvas
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_char) && $stable(off_canvas))
		else $error("result word changed while stalled");

	// an off-canvas read carries no character
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && off_canvas |-> read_char == '0)
		else $error("off-canvas result with nonzero character");

	// one command in flight: an accepted word closes the input
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	// the frame store is still being cleared right after reset
	a_init_busy: assert property (@(posedge clk)
		!arst_n |=> in_stall)
		else $error("input open during the clearing pass");

endmodule

bind char_canvas_draw_engine_top ccde_chk u_chk (.*);
